[design/ast_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the aging slot table.
package ast_pkg;

    localparam int SLOTS  = 32;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int OBJ_W  = 16;
    localparam int AGE_W  = 32;
    localparam int EL_W   = 16;
    localparam int OP_W   = 3;
    localparam int KIND_W = 2;
    localparam int IDX_W  = 5;

    localparam logic [AGE_W-1:0] LIFETIME_RESET = 32'd5000;

    localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
    localparam logic [OP_W-1:0] OP_TICK    = 3'd1;
    localparam logic [OP_W-1:0] OP_DESTROY = 3'd2;
    localparam logic [OP_W-1:0] OP_FORGET  = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY   = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;

    localparam logic [KIND_W-1:0] KIND_OK        = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DESTROY   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 2'd2;

    // where the payload of a result word comes from
    typedef enum logic [2:0] {
        SRC_INS,
        SRC_WALK,
        SRC_WALK_AGE,
        SRC_ID,
        SRC_ZERO,
        SRC_BEST
    } src_t;

    typedef struct packed {
        logic              ins_write;
        logic              walk_start;
        logic              walk_step;
        logic              age_write;
        logic              clr_walk;
        logic              clr_best;
        logic              best_update;
        logic              scan_step;
        logic              fp_from_scan;
        logic              fp_from_best;
        logic              fp_zero;
        logic              out_load;
        logic [KIND_W-1:0] out_kind;
        logic              out_last;
        src_t              out_src;
    } cmd_t;

    typedef struct packed {
        logic rd_valid;
        logic walk_last;
        logic cur_active;
        logic cur_match;
        logic cur_expire;
        logic scan_free;
        logic scan_last;
        logic out_free;
    } sts_t;

endpackage

[design/ast_ctrl.sv]
// Sequencer for the aging slot table: decodes each operation and steps the datapath.
module ast_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    input  logic [ast_pkg::OP_W-1:0] opcode,
    output logic                     req_ready,
    input  ast_pkg::sts_t            sts,
    output ast_pkg::cmd_t            cmd
);
    import ast_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_INS       = 3'd1;
    localparam logic [2:0] S_SCAN      = 3'd2;
    localparam logic [2:0] S_EVICT     = 3'd3;
    localparam logic [2:0] S_EVICT_OUT = 3'd4;
    localparam logic [2:0] S_WALK      = 3'd5;
    localparam logic [2:0] S_DONE      = 3'd6;

    logic [2:0]      state_reg;
    logic [2:0]      state_next;
    logic [OP_W-1:0] op_reg;
    logic [OP_W-1:0] op_next;
    logic            adv;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.out_src = SRC_ZERO;
        state_next = state_reg;
        op_next    = op_reg;
        adv        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next = opcode;
                    unique case (opcode)
                        OP_INSERT:
                        begin
                            state_next = S_INS;
                        end
                        OP_TICK, OP_DESTROY, OP_FORGET, OP_QUERY:
                        begin
                            cmd.walk_start = 1'b1;
                            state_next     = S_WALK;
                        end
                        OP_CLEAR:
                        begin
                            cmd.walk_start = 1'b1;
                            cmd.fp_zero    = 1'b1;
                            state_next     = S_WALK;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_INS:
            begin
                cmd.ins_write = 1'b1;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.out_kind = KIND_OK;
                cmd.out_src  = SRC_INS;
                priority if (sts.scan_free)
                begin
                    if (sts.out_free)
                    begin
                        cmd.out_load     = 1'b1;
                        cmd.out_last     = 1'b1;
                        cmd.fp_from_scan = 1'b1;
                        state_next       = S_IDLE;
                    end
                end
                else if (sts.scan_last)
                begin
                    // table full: report the insert, then hunt for the oldest entry
                    if (sts.out_free)
                    begin
                        cmd.out_load   = 1'b1;
                        cmd.walk_start = 1'b1;
                        state_next     = S_EVICT;
                    end
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_EVICT:
            begin
                if (sts.rd_valid)
                begin
                    cmd.best_update = 1'b1;
                    cmd.walk_step   = 1'b1;
                    if (sts.walk_last)
                    begin
                        state_next = S_EVICT_OUT;
                    end
                end
            end
            S_EVICT_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.out_kind     = KIND_DESTROY;
                    cmd.out_last     = 1'b1;
                    cmd.out_src      = SRC_BEST;
                    cmd.clr_best     = 1'b1;
                    cmd.fp_from_best = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_WALK:
            begin
                if (sts.rd_valid)
                begin
                    unique case (op_reg)
                        OP_TICK:
                        begin
                            priority if (!sts.cur_active)
                            begin
                                adv = 1'b1;
                            end
                            else if (sts.cur_expire)
                            begin
                                if (sts.out_free)
                                begin
                                    cmd.out_load = 1'b1;
                                    cmd.out_kind = KIND_DESTROY;
                                    cmd.out_src  = SRC_WALK;
                                    cmd.clr_walk = 1'b1;
                                    adv          = 1'b1;
                                end
                            end
                            else
                            begin
                                cmd.age_write = 1'b1;
                                adv           = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            priority if (!sts.cur_active)
                            begin
                                adv = 1'b1;
                            end
                            else if (sts.out_free)
                            begin
                                cmd.out_load = 1'b1;
                                cmd.out_kind = KIND_DESTROY;
                                cmd.out_src  = SRC_WALK;
                                cmd.clr_walk = 1'b1;
                                adv          = 1'b1;
                            end
                        end
                        default:
                        begin
                            // lookup by id: first active match ends the walk
                            priority if (sts.cur_active && sts.cur_match)
                            begin
                                if (sts.out_free)
                                begin
                                    cmd.out_load = 1'b1;
                                    cmd.out_last = 1'b1;
                                    cmd.out_kind = (op_reg == OP_DESTROY) ? KIND_DESTROY
                                                                          : KIND_OK;
                                    cmd.out_src  = (op_reg == OP_QUERY) ? SRC_WALK_AGE
                                                                        : SRC_WALK;
                                    cmd.clr_walk = (op_reg != OP_QUERY);
                                    state_next   = S_IDLE;
                                end
                            end
                            else
                            begin
                                adv = 1'b1;
                            end
                        end
                    endcase
                    if (adv)
                    begin
                        cmd.walk_step = 1'b1;
                        if (sts.walk_last)
                        begin
                            state_next = S_DONE;
                        end
                    end
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    if (op_reg == OP_DESTROY || op_reg == OP_FORGET || op_reg == OP_QUERY)
                    begin
                        cmd.out_kind = KIND_NOT_FOUND;
                        cmd.out_src  = SRC_ID;
                    end
                    else
                    begin
                        cmd.out_kind = KIND_OK;
                        cmd.out_src  = SRC_ZERO;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_INSERT;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

endmodule

[design/ast_dpath.sv]
// Datapath for the aging slot table: slot store, active bits, walk/scan counters, result register.
module ast_dpath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [ast_pkg::OBJ_W-1:0]  object_id,
    input  logic [ast_pkg::EL_W-1:0]   elapsed_ms,
    input  logic [ast_pkg::AGE_W-1:0]  lifetime,
    input  ast_pkg::cmd_t              cmd,
    output ast_pkg::sts_t              sts,
    input  logic                       rsp_ready,
    output logic                       rsp_valid,
    output logic [ast_pkg::KIND_W-1:0] kind,
    output logic [ast_pkg::OBJ_W-1:0]  result_object,
    output logic [ast_pkg::IDX_W-1:0]  slot_index,
    output logic [ast_pkg::AGE_W-1:0]  age_ms,
    output logic                       last
);
    import ast_pkg::*;

    localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(SLOTS - 1);

    // slot store: {object, age}; contents of inactive slots never matter
    logic [OBJ_W+AGE_W-1:0] mem [SLOTS];
    logic [OBJ_W+AGE_W-1:0] rd_word_reg;
    logic                   rd_en;
    logic [SLOT_W-1:0]      rd_addr;
    logic                   wr_en;
    logic [SLOT_W-1:0]      wr_addr;
    logic [OBJ_W+AGE_W-1:0] wr_data;

    logic [SLOTS-1:0]  active_reg;
    logic [SLOT_W-1:0] fp_reg;
    logic [SLOT_W-1:0] scan_q_reg;
    logic [SLOT_W-1:0] scan_cnt_reg;
    logic [SLOT_W-1:0] walk_idx_reg;
    logic              rd_valid_reg;
    logic              out_valid_reg;

    logic [OBJ_W-1:0]  id_reg;
    logic [EL_W-1:0]   el_reg;
    logic [SLOT_W-1:0] best_idx_reg;
    logic [AGE_W-1:0]  best_age_reg;
    logic [OBJ_W-1:0]  best_obj_reg;

    logic [KIND_W-1:0] kind_reg;
    logic [OBJ_W-1:0]  obj_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [AGE_W-1:0]  age_reg;
    logic              last_reg;

    logic [OBJ_W-1:0]  rd_obj;
    logic [AGE_W-1:0]  rd_age;
    logic [AGE_W:0]    sum;
    logic [AGE_W-1:0]  new_age;
    logic              walk_last;
    logic              out_free;
    logic [OBJ_W-1:0]  out_obj;
    logic [SLOT_W-1:0] out_slot;
    logic [AGE_W-1:0]  out_age;

    function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] v);
        wrap_inc = (v == SLOT_MAX) ? '0 : v + SLOT_W'(1);
    endfunction

    assign rd_obj    = rd_word_reg[OBJ_W+AGE_W-1:AGE_W];
    assign rd_age    = rd_word_reg[AGE_W-1:0];
    assign sum       = {1'b0, rd_age} + (AGE_W+1)'(el_reg);
    assign new_age   = sum[AGE_W] ? '1 : sum[AGE_W-1:0];
    assign walk_last = (walk_idx_reg == SLOT_MAX);
    assign out_free  = !out_valid_reg || rsp_ready;

    assign rd_en   = cmd.walk_start || (cmd.walk_step && !walk_last);
    assign rd_addr = cmd.walk_start ? '0 : walk_idx_reg + SLOT_W'(1);
    assign wr_en   = cmd.ins_write || cmd.age_write;
    assign wr_addr = cmd.ins_write ? fp_reg : walk_idx_reg;
    assign wr_data = cmd.ins_write ? {id_reg, {AGE_W{1'b0}}} : {rd_obj, new_age};

    always_comb
    begin
        sts.rd_valid   = rd_valid_reg;
        sts.walk_last  = walk_last;
        sts.cur_active = active_reg[walk_idx_reg];
        sts.cur_match  = (rd_obj == id_reg);
        sts.cur_expire = (new_age > lifetime);
        sts.scan_free  = !active_reg[scan_q_reg];
        sts.scan_last  = (scan_cnt_reg == SLOT_MAX);
        sts.out_free   = out_free;
    end

    always_comb
    begin
        out_obj  = '0;
        out_slot = '0;
        out_age  = '0;
        unique case (cmd.out_src)
            SRC_INS:
            begin
                out_obj  = id_reg;
                out_slot = fp_reg;
            end
            SRC_WALK:
            begin
                out_obj  = rd_obj;
                out_slot = walk_idx_reg;
            end
            SRC_WALK_AGE:
            begin
                out_obj  = rd_obj;
                out_slot = walk_idx_reg;
                out_age  = rd_age;
            end
            SRC_ID:
            begin
                out_obj = id_reg;
            end
            SRC_BEST:
            begin
                out_obj  = best_obj_reg;
                out_slot = best_idx_reg;
            end
            default:
            begin
                out_obj = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            fp_reg        <= '0;
            scan_q_reg    <= '0;
            scan_cnt_reg  <= '0;
            walk_idx_reg  <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ins_write)
            begin
                active_reg[fp_reg] <= 1'b1;
                scan_q_reg         <= wrap_inc(fp_reg);
                scan_cnt_reg       <= SLOT_W'(1);
            end
            if (cmd.clr_walk)
            begin
                active_reg[walk_idx_reg] <= 1'b0;
            end
            if (cmd.clr_best)
            begin
                active_reg[best_idx_reg] <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                scan_q_reg   <= wrap_inc(scan_q_reg);
                scan_cnt_reg <= scan_cnt_reg + SLOT_W'(1);
            end
            priority if (cmd.fp_zero)
            begin
                fp_reg <= '0;
            end
            else if (cmd.fp_from_scan)
            begin
                fp_reg <= scan_q_reg;
            end
            else if (cmd.fp_from_best)
            begin
                fp_reg <= best_idx_reg;
            end
            priority if (cmd.walk_start)
            begin
                walk_idx_reg <= '0;
                rd_valid_reg <= 1'b1;
            end
            else if (cmd.walk_step)
            begin
                if (walk_last)
                begin
                    rd_valid_reg <= 1'b0;
                end
                else
                begin
                    walk_idx_reg <= walk_idx_reg + SLOT_W'(1);
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_reg <= object_id;
            el_reg <= elapsed_ms;
        end
        // greatest age wins, ties keep the lower slot
        if (cmd.best_update && (walk_idx_reg == '0 || rd_age > best_age_reg))
        begin
            best_idx_reg <= walk_idx_reg;
            best_age_reg <= rd_age;
            best_obj_reg <= rd_obj;
        end
        if (cmd.out_load)
        begin
            kind_reg <= cmd.out_kind;
            obj_reg  <= out_obj;
            idx_reg  <= IDX_W'(out_slot);
            age_reg  <= out_age;
            last_reg <= cmd.out_last;
        end
    end

    assign rsp_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign result_object = obj_reg;
    assign slot_index    = idx_reg;
    assign age_ms        = age_reg;
    assign last          = last_reg;

endmodule

[design/aging_slot_table_with_eviction.sv]
// Top level of the aging slot table: APB lifetime register, sequencer and datapath.
//
// Usage notes
// - Request channel (req_valid/req_ready): one word carries opcode, object_id and
//   elapsed_ms. req_ready is high only while the sequencer is idle; one operation
//   is worked at a time.
// - Response channel (rsp_valid/rsp_ready): one word per result, 'last' marks the
//   final word of an operation. A registered output stage holds the word, so the
//   next request is taken while the final word still waits for the receiver.
// - Steps: the walk over the slot store (single read port, registered read data) and
//   the free scan each take one slot per cycle; a stalled receiver holds the walk:
//     tick, clear all           : walk over every slot
//     destroy/forget/query by id: walk up to the first active match
//     insert                    : write, then scan for the next free slot; with a full
//                                 table a further walk over every slot for the eviction
//     unused opcode             : no walk, only the closing ok word
// - A stalled receiver simply holds the walk: nothing is lost or repeated.
// - Reset (rst_n, async, active low) clears the active bits, free pointer and all
//   control state and loads lifetime_ms with 5000; the store needs no clearing pass.
// - lifetime_ms is written through APB at byte address 0, by the user only while the block is idle; not enforced.
module aging_slot_table_with_eviction (
    input  logic                       clk,
    input  logic                       rst_n,
    // request channel
    input  logic                       req_valid,
    output logic                       req_ready,
    input  logic [ast_pkg::OP_W-1:0]   opcode,
    input  logic [ast_pkg::OBJ_W-1:0]  object_id,
    input  logic [ast_pkg::EL_W-1:0]   elapsed_ms,
    // response channel
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output logic [ast_pkg::KIND_W-1:0] kind,
    output logic [ast_pkg::OBJ_W-1:0]  result_object,
    output logic [ast_pkg::IDX_W-1:0]  slot_index,
    output logic [ast_pkg::AGE_W-1:0]  age_ms,
    output logic                       last,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import ast_pkg::*;

    // register select: paddr[2] picks the 32-bit register slot
    localparam logic REG_SEL_LIFETIME = 1'b0;

    logic [AGE_W-1:0] lifetime_reg;
    logic             cfg_write;
    logic             accept;
    cmd_t             cmd;
    sts_t             sts;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_SEL_LIFETIME);
    assign prdata    = (paddr[2] == REG_SEL_LIFETIME) ? lifetime_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lifetime_reg <= LIFETIME_RESET;
        end
        else if (cfg_write)
        begin
            lifetime_reg <= pwdata;
        end
    end

    assign accept = req_valid && req_ready;

    // sequencer: decodes the opcode and steps the walks
    ast_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .opcode    (opcode),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // slot store, counters and output word register
    ast_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .object_id     (object_id),
        .elapsed_ms    (elapsed_ms),
        .lifetime      (lifetime_reg),
        .cmd           (cmd),
        .sts           (sts),
        .rsp_ready     (rsp_ready),
        .rsp_valid     (rsp_valid),
        .kind          (kind),
        .result_object (result_object),
        .slot_index    (slot_index),
        .age_ms        (age_ms),
        .last          (last)
    );

endmodule

[bench/aging_slot_table_with_eviction_tb.sv]
// Self-checking bench for the aging slot table: directed and random operations against a local table model.
module aging_slot_table_with_eviction_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ast_pkg::*;

    // opcodes the block leaves unused; both must answer a bare ok word
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    // lifetime_ms is register 0, byte address 0
    localparam logic [2:0] LIFETIME_ADDR = 3'd0;

    // a full walk plus eviction walk with margin; used before config writes and at the end
    localparam int SETTLE_CYCLES = 2 * SLOTS + 8;
    // receiver hold-off for the back-pressure test
    localparam int HOLD_CYCLES = 300;
    // cycles without any accepted word before the run is declared hung
    localparam int QUIET_LIMIT = 4000;

    // one result word as the block presents it
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [OBJ_W-1:0]  obj;
        logic [IDX_W-1:0]  slot;
        logic [AGE_W-1:0]  age;
        logic              fin;
    } result_word_t;

    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_PERIODIC, RX_HEAVY} rx_style_t;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              req_valid  = 1'b0;
    logic              req_ready;
    logic [OP_W-1:0]   opcode     = '0;
    logic [OBJ_W-1:0]  object_id  = '0;
    logic [EL_W-1:0]   elapsed_ms = '0;
    logic              rsp_valid;
    logic              rsp_ready  = 1'b0;
    logic [KIND_W-1:0] kind;
    logic [OBJ_W-1:0]  result_object;
    logic [IDX_W-1:0]  slot_index;
    logic [AGE_W-1:0]  age_ms;
    logic              last;
    logic              psel       = 1'b0;
    logic              penable    = 1'b0;
    logic              pwrite     = 1'b0;
    logic [2:0]        paddr      = '0;
    logic [31:0]       pwdata     = '0;
    logic [31:0]       prdata;
    logic              pready;

    // local copy of the slot table and its lifetime setting
    bit                tbl_live [SLOTS];
    logic [OBJ_W-1:0]  tbl_id [SLOTS];
    logic [AGE_W-1:0]  tbl_age [SLOTS];
    int unsigned       tbl_next_free = 0;
    logic [AGE_W-1:0]  lifetime_cfg  = LIFETIME_RESET;

    // words still owed by the block, oldest first
    result_word_t      awaited_words [$];

    int                mismatch_count = 0;
    int                quiet_cycles   = 0;

    // sender burst state
    int                burst_left  = 0;
    bit                req_offered = 1'b0;

    // receiver state: hold-off requests from the tests, served by the receiver itself
    int                hold_requests = 0;
    int                hold_served   = 0;
    int                hold_left     = 0;
    rx_style_t         rx_style      = RX_FREE;
    int                rx_style_left = 0;
    int unsigned       rx_count      = 0;

    aging_slot_table_with_eviction DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .opcode        (opcode),
        .object_id     (object_id),
        .elapsed_ms    (elapsed_ms),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .kind          (kind),
        .result_object (result_object),
        .slot_index    (slot_index),
        .age_ms        (age_ms),
        .last          (last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Table model
    // ------------------------------------------------------------------

    function automatic void note_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s", $time, what);
    endfunction

    function automatic void queue_word(logic [KIND_W-1:0] k, logic [OBJ_W-1:0] obj, int slot,
                                       logic [AGE_W-1:0] age, logic fin);
        result_word_t w;
        w.kind = k;
        w.obj  = obj;
        w.slot = IDX_W'(slot);
        w.age  = age;
        w.fin  = fin;
        awaited_words.push_back(w);
    endfunction

    function automatic void drop_slot(int i);
        tbl_live[i] = 1'b0;
        tbl_id[i]   = '0;
        tbl_age[i]  = '0;
    endfunction

    // apply one accepted operation to the table and queue the words it must produce
    function automatic void apply_op_to_table(logic [OP_W-1:0] op, logic [OBJ_W-1:0] id,
                                              logic [EL_W-1:0] el);
        int          put;
        int          nxt;
        int          oldest;
        int          hit;
        bit          room;
        logic [AGE_W:0] sum;
        hit = -1;
        case (op)
            OP_INSERT:
            begin
                put = tbl_next_free;
                tbl_live[put] = 1'b1;
                tbl_id[put]   = id;
                tbl_age[put]  = '0;
                room = 1'b0;
                nxt  = put;
                for (int k = 1; k < SLOTS; k++)
                    if (!room && !tbl_live[(put + k) % SLOTS])
                    begin
                        room = 1'b1;
                        nxt  = (put + k) % SLOTS;
                    end
                if (room)
                begin
                    tbl_next_free = nxt;
                    queue_word(KIND_OK, id, put, '0, 1'b1);
                end
                else
                begin
                    // table full: oldest goes, ties to the lowest index
                    oldest = 0;
                    for (int i = 1; i < SLOTS; i++)
                        if (tbl_age[i] > tbl_age[oldest])
                            oldest = i;
                    queue_word(KIND_OK, id, put, '0, 1'b0);
                    queue_word(KIND_DESTROY, tbl_id[oldest], oldest, '0, 1'b1);
                    drop_slot(oldest);
                    tbl_next_free = oldest;
                end
            end
            OP_TICK:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (tbl_live[i])
                    begin
                        sum = {1'b0, tbl_age[i]} + el;
                        tbl_age[i] = sum[AGE_W] ? '1 : sum[AGE_W-1:0];
                        if (tbl_age[i] > lifetime_cfg)
                        begin
                            queue_word(KIND_DESTROY, tbl_id[i], i, '0, 1'b0);
                            drop_slot(i);
                        end
                    end
                queue_word(KIND_OK, '0, 0, '0, 1'b1);
            end
            OP_DESTROY, OP_FORGET, OP_QUERY:
            begin
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (tbl_live[i] && tbl_id[i] == id)
                        hit = i;
                if (hit < 0)
                    queue_word(KIND_NOT_FOUND, id, 0, '0, 1'b1);
                else if (op == OP_DESTROY)
                begin
                    queue_word(KIND_DESTROY, id, hit, '0, 1'b1);
                    drop_slot(hit);
                end
                else if (op == OP_FORGET)
                begin
                    queue_word(KIND_OK, id, hit, '0, 1'b1);
                    drop_slot(hit);
                end
                else
                    queue_word(KIND_OK, id, hit, tbl_age[hit], 1'b1);
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (tbl_live[i])
                    begin
                        queue_word(KIND_DESTROY, tbl_id[i], i, '0, 1'b0);
                        drop_slot(i);
                    end
                tbl_next_free = 0;
                queue_word(KIND_OK, '0, 0, '0, 1'b1);
            end
            default:
                queue_word(KIND_OK, '0, 0, '0, 1'b1);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one request word; bursts of random length, random gaps between them.
    // valid stays up across a burst, so back-to-back words see no bubble.
    task automatic send_word(input logic [OP_W-1:0] op, input logic [OBJ_W-1:0] id,
                             input logic [EL_W-1:0] el);
        int gap;
        if (burst_left == 0 || !req_offered)
        begin
            if (req_offered)
                req_valid <= 1'b0;
            req_offered = 1'b0;
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        req_valid  <= 1'b1;
        opcode     <= op;
        object_id  <= id;
        elapsed_ms <= el;
        req_offered = 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        apply_op_to_table(op, id, el);
        burst_left--;
    endtask

    // drop valid and wait until every owed word has come back
    task automatic wait_drained();
        if (req_offered)
            req_valid <= 1'b0;
        req_offered = 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
    endtask

    // one APB transfer to the lifetime register: setup cycle, then access cycle
    task automatic apb_transfer(input bit wr, input logic [31:0] wdata,
                                output logic [31:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= LIFETIME_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // write lifetime while the block is idle, then read it back
    task automatic set_lifetime(input logic [31:0] value);
        logic [31:0] rd;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        apb_transfer(1'b1, value, rd);
        lifetime_cfg = value;
        apb_transfer(1'b0, '0, rd);
        if (rd !== value)
            note_mismatch($sformatf("lifetime readback: expected %0d, got %0d", value, rd));
    endtask

    // ------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------

    // Receiver: changes stall style every so often; a hold-off request from a test
    // takes priority and is counted out here.
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (rx_style_left == 0)
        begin
            rx_style      = rx_style_t'($urandom_range(0, 3));
            rx_style_left = $urandom_range(40, 160);
        end
        else
            rx_style_left--;
        rx_count++;
        if (hold_left != 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else
            case (rx_style)
                RX_FREE:     rsp_ready <= 1'b1;
                RX_LIGHT:    rsp_ready <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC: rsp_ready <= (rx_count % 4 != 3);
                default:     rsp_ready <= ($urandom_range(0, 9) < 3);
            endcase
    end

    // every accepted word is checked against the oldest owed one
    always @(posedge clk)
    begin : word_check
        result_word_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (awaited_words.size() == 0)
                note_mismatch($sformatf(
                    "unexpected word: kind %0d obj %h slot %0d age %0d last %0b",
                    kind, result_object, slot_index, age_ms, last));
            else
            begin
                want = awaited_words.pop_front();
                if (kind !== want.kind || result_object !== want.obj ||
                    slot_index !== want.slot || age_ms !== want.age || last !== want.fin)
                    note_mismatch($sformatf(
                        {"word mismatch: expected kind %0d obj %h slot %0d age %0d last %0b,",
                         " got kind %0d obj %h slot %0d age %0d last %0b"},
                        want.kind, want.obj, want.slot, want.age, want.fin,
                        kind, result_object, slot_index, age_ms, last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: counts cycles in which nothing at all is accepted
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset value of the register, spare opcodes and misses on an empty table
    task automatic test_reset_state();
        logic [31:0] rd;
        apb_transfer(1'b0, '0, rd);
        if (rd !== LIFETIME_RESET)
            note_mismatch($sformatf("lifetime after reset: expected %0d, got %0d",
                                    LIFETIME_RESET, rd));
        send_word(OP_SPARE_LO, 16'hFFFF, 16'hFFFF);
        send_word(OP_SPARE_HI, 16'h0000, 16'h0000);
        send_word(OP_QUERY, 16'h0000, 16'h0000);
        send_word(OP_DESTROY, 16'hFFFF, 16'h0000);
        send_word(OP_FORGET, 16'h1234, 16'h0000);
        // tick on an empty table: only the closing ok word
        send_word(OP_TICK, 16'h0000, 16'hFFFF);
    endtask

    // every operation once, duplicate ids, expiry on tick, clear all
    task automatic test_basic_ops();
        send_word(OP_INSERT, 16'hFFFF, 16'h0000);
        send_word(OP_INSERT, 16'h0000, 16'h0000);
        send_word(OP_INSERT, 16'hA5A5, 16'h0000);
        send_word(OP_INSERT, 16'hA5A5, 16'h0000);
        send_word(OP_TICK, 16'h0000, 16'd1000);
        // duplicates: lookups touch the lowest matching slot only
        send_word(OP_QUERY, 16'hA5A5, 16'h0000);
        send_word(OP_FORGET, 16'hA5A5, 16'h0000);
        send_word(OP_QUERY, 16'hA5A5, 16'h0000);
        send_word(OP_DESTROY, 16'h0000, 16'h0000);
        send_word(OP_TICK, 16'h0000, 16'h0000);
        // largest step: every remaining entry expires
        send_word(OP_TICK, 16'hFFFF, 16'hFFFF);
        send_word(OP_INSERT, 16'h5A5A, 16'h0000);
        send_word(OP_CLEAR, 16'h0000, 16'h0000);
        send_word(OP_CLEAR, 16'hFFFF, 16'h0000);
    endtask

    // Fill the table. With every age still zero the eviction picks slot 0,
    // including the entry just written; later the oldest by age goes.
    task automatic test_fill_and_evict();
        for (int k = 0; k < SLOTS - 1; k++)
            send_word(OP_INSERT, OBJ_W'(16'h0100 + k), EL_W'($urandom));
        send_word(OP_INSERT, 16'h01FF, 16'h0000);
        send_word(OP_INSERT, 16'h0200, 16'h0000);
        send_word(OP_TICK, 16'h0000, 16'd10);
        send_word(OP_FORGET, 16'h0105, 16'h0000);
        send_word(OP_INSERT, 16'h0201, 16'h0000);
        send_word(OP_INSERT, 16'h0202, 16'h0000);
        send_word(OP_TICK, 16'h0000, 16'd100);
        send_word(OP_INSERT, 16'h0203, 16'h0000);
        send_word(OP_INSERT, 16'h0204, 16'h0000);
    endtask

    // Receiver holds off while a full-table expiry and more requests are offered,
    // so the output stage and the sequencer back up into the request channel.
    task automatic test_backpressure();
        hold_requests++;
        send_word(OP_TICK, 16'h0000, 16'hFFFF);
        repeat (8)
            send_word(OP_INSERT, OBJ_W'($urandom), EL_W'($urandom));
        send_word(OP_QUERY, OBJ_W'($urandom), 16'h0000);
        send_word(OP_TICK, 16'h0000, 16'h0000);
    endtask

    // lifetime at zero, at a boundary and at its maximum
    task automatic test_lifetime_bounds();
        set_lifetime(32'd0);
        send_word(OP_INSERT, 16'h0F0F, 16'h0000);
        send_word(OP_TICK, 16'h0000, 16'h0000);
        send_word(OP_TICK, 16'h0000, 16'd1);
        // age equal to the lifetime survives, one more ms expires it
        set_lifetime(32'd100);
        send_word(OP_INSERT, 16'hF0F0, 16'h0000);
        send_word(OP_TICK, 16'h0000, 16'd100);
        send_word(OP_QUERY, 16'hF0F0, 16'h0000);
        send_word(OP_TICK, 16'h0000, 16'd1);
        set_lifetime(32'hFFFF_FFFF);
        send_word(OP_INSERT, 16'h3C3C, 16'h0000);
        repeat (4)
            send_word(OP_TICK, 16'h0000, 16'hFFFF);
        send_word(OP_QUERY, 16'h3C3C, 16'h0000);
        send_word(OP_FORGET, 16'h3C3C, 16'h0000);
    endtask

    // Random traffic in three lifetime settings: moderate, huge (table fills and
    // evicts) and short (entries die within a few ticks). Lookups mostly name a
    // live id so they hit; a share is noise.
    task automatic test_random_traffic();
        logic [OBJ_W-1:0] id_pool [8];
        logic [31:0]      life;
        logic [OP_W-1:0]  op;
        logic [OBJ_W-1:0] id;
        logic [EL_W-1:0]  el;
        int               el_span;
        int               ins_pct;
        int               items;
        int               pick;
        int               start;
        foreach (id_pool[i])
            id_pool[i] = OBJ_W'($urandom);
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    life = $urandom_range(2000, 30000);
                    el_span = 3000;
                    ins_pct = 40;
                    items = 80;
                end
                1:
                begin
                    life = $urandom;
                    el_span = 65535;
                    ins_pct = 60;
                    items = 100;
                end
                default:
                begin
                    life = $urandom_range(0, 400);
                    el_span = 200;
                    ins_pct = 40;
                    items = 80;
                end
            endcase
            set_lifetime(life);
            repeat (items)
            begin
                case ($urandom_range(0, 9))
                    0:       el = '0;
                    1:       el = EL_W'($urandom);
                    default: el = EL_W'($urandom_range(0, el_span));
                endcase
                id = id_pool[$urandom_range(0, 7)];
                pick = $urandom_range(0, 99);
                if (pick < ins_pct)
                begin
                    op = OP_INSERT;
                    if ($urandom_range(0, 2) == 0)
                        id = OBJ_W'($urandom);
                end
                else
                begin
                    start = $urandom_range(0, SLOTS - 1);
                    if ($urandom_range(0, 3) != 0)
                        for (int k = 0; k < SLOTS; k++)
                            if (tbl_live[(start + k) % SLOTS])
                                id = tbl_id[(start + k) % SLOTS];
                    if ($urandom_range(0, 5) == 0)
                        id = OBJ_W'($urandom);
                    pick = $urandom_range(0, 99);
                    if (pick < 35)
                        op = OP_TICK;
                    else if (pick < 55)
                        op = OP_DESTROY;
                    else if (pick < 70)
                        op = OP_FORGET;
                    else if (pick < 88)
                        op = OP_QUERY;
                    else if (pick < 94 && ph != 1)
                        op = OP_CLEAR;
                    else
                        op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
                end
                send_word(op, id, el);
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_basic_ops();
        test_fill_and_evict();
        test_backpressure();
        test_lifetime_bounds();
        test_random_traffic();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
